### sv/grr_pkg.sv
// Shared types, codes and constants of the glyph row renderer.
package grr_pkg;

  // Input operation codes; code 3 is unused and does nothing
  typedef enum logic [1:0] {
    OP_RENDER = 2'd0,
    OP_DESC   = 2'd1,
    OP_BYTE   = 2'd2
  } grr_op_t;

  localparam logic [6:0]  FIRST_CODE = 7'd31;     // glyph number = code - FIRST_CODE
  localparam logic [15:0] BG_RESET   = 16'h20c3;
  localparam logic [15:0] LEVEL_STEP = 16'h4208;  // one grey step, 0x0841 * 8
  localparam int          START_W    = 12;        // bitmap start address width
  localparam int          RAW_W      = 13;        // start + row byte offset, before wrap
  localparam int          CMP_W      = 17;        // wide enough for any size compare
  localparam int          WORDS      = 5;         // words per rendered row

  typedef struct packed {
    logic [3:0]        w;
    logic [4:0]        h;
    logic [2:0]        ox;
    logic signed [5:0] oy;
    logic [START_W-1:0] start;
  } grr_glyph_t;

  // One job for the back end: a bitmap byte write or a row fetch
  typedef struct packed {
    logic       wr;
    logic       hit;
    logic [1:0] phase;
    logic [3:0] w;
    logic [2:0] ox;
    logic [7:0] data;
  } grr_job_t;

  typedef enum logic [3:0] {
    F_B0   = 4'b0001,
    F_B1   = 4'b0010,
    F_B2   = 4'b0100,
    F_HAND = 4'b1000
  } grr_fetch_t;

  typedef enum logic [1:0] {
    LVL_0 = 2'd0,
    LVL_1 = 2'd1,
    LVL_2 = 2'd2,
    LVL_3 = 2'd3
  } grr_level_t;

  function automatic logic [15:0] level_offset(input logic [1:0] lvl);
    logic [15:0] r;
    case (grr_level_t'(lvl))
      LVL_0:   r = 16'h0000;
      LVL_1:   r = LEVEL_STEP;
      LVL_2:   r = 16'(LEVEL_STEP << 1);
      LVL_3:   r = 16'(LEVEL_STEP + (LEVEL_STEP << 1));
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

### sv/grr_queue.sv
// Two-entry queue with full and empty flags.
module grr_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= din;
  end

endmodule

### sv/grr_front.sv
// Front end: accepts items, keeps the glyph table, locates the bitmap row.
module grr_front #(
  parameter int TEXT_LINE_HEIGHT = 10,
  parameter int GLYPH_COUNT      = 96,
  parameter int BITMAP_BYTES     = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_operation,
  input  logic [6:0]                      in_char_code,
  input  logic [4:0]                      in_text_row,
  input  logic [11:0]                     in_table_address,
  input  logic [7:0]                      in_bitmap_byte,
  input  logic [3:0]                      in_glyph_width,
  input  logic [4:0]                      in_glyph_height,
  input  logic [2:0]                      in_glyph_offset_x,
  input  logic signed [5:0]               in_glyph_offset_y,
  input  logic [11:0]                     in_glyph_bitmap_start,
  output logic                            jq_push,
  input  logic                            jq_full,
  output grr_pkg::grr_job_t               jq_job,
  output logic [$clog2(BITMAP_BYTES)-1:0] jq_addr
);
  import grr_pkg::*;

  localparam int GW      = $clog2(GLYPH_COUNT);
  localparam int AW      = $clog2(BITMAP_BYTES);
  localparam int RSH     = 30;
  localparam int RECIP_W = RSH - AW + 1;
  localparam int PW      = RAW_W + RECIP_W;
  localparam int QW      = (PW > RSH) ? PW - RSH : 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RSH) / BITMAP_BYTES);
  localparam logic [CMP_W-1:0]   BMAX  = CMP_W'(BITMAP_BYTES);
  localparam logic [CMP_W-1:0]   GMAX  = CMP_W'(GLYPH_COUNT);
  localparam logic signed [8:0]  EY_BIAS = 9'(4 - TEXT_LINE_HEIGHT);

  grr_glyph_t gt_mem [GLYPH_COUNT];

  logic          stall, acc;
  logic [6:0]    gn;
  logic          gn_ok, gaddr_ok, baddr_ok;

  // stage 1: item fields plus glyph descriptor
  logic          s1_v_r, s1_wr_r, s1_gn_ok_r;
  grr_glyph_t    s1_g_r;
  logic [4:0]    s1_row_r;
  logic [11:0]   s1_addr_r;
  logic [7:0]    s1_byte_r;
  // stage 2: unwrapped byte address
  logic          s2_v_r;
  grr_job_t      s2_job_r;
  logic [RAW_W-1:0] s2_raw_r;
  // stage 3: quotient estimate for the wrap
  logic          s3_v_r;
  grr_job_t      s3_job_r;
  logic [RAW_W-1:0] s3_raw_r;
  logic [QW-1:0] s3_q_r;

  logic signed [8:0] ey;
  logic [8:0]    bi;
  logic          hit;
  grr_job_t      job1;
  logic [RAW_W-1:0] raw1;
  logic [PW-1:0] prod;
  logic [CMP_W-1:0] rem0, rem1;

  assign stall   = s3_v_r && jq_full;
  assign in_full = stall;
  assign acc     = in_push && !stall;

  assign gn       = in_char_code - FIRST_CODE;
  assign gn_ok    = (in_char_code >= FIRST_CODE) && (CMP_W'(gn) < GMAX);
  assign gaddr_ok = CMP_W'(in_table_address) < GMAX;
  assign baddr_ok = CMP_W'(in_table_address) < BMAX;

  always_ff @(posedge clk) begin
    if (acc && in_operation == OP_DESC && gaddr_ok) begin
      gt_mem[GW'(in_table_address)] <= '{w: in_glyph_width, h: in_glyph_height,
        ox: in_glyph_offset_x, oy: in_glyph_offset_y, start: in_glyph_bitmap_start};
    end
    if (acc) s1_g_r <= gt_mem[GW'(gn)];
  end

  // stage 1 logic: glyph row, hit test, bitmap pixel index
  always_comb begin
    ey   = $signed({4'b0, s1_row_r}) + $signed({4'b0, s1_g_r.h}) + 9'(s1_g_r.oy) + EY_BIAS;
    hit  = s1_gn_ok_r && !ey[8] && (ey[7:0] < {3'b0, s1_g_r.h}) && (s1_g_r.w != 4'd0);
    bi   = {5'b0, s1_g_r.w} * {4'b0, ey[4:0]};
    raw1 = s1_wr_r ? RAW_W'(s1_addr_r) : (RAW_W'(s1_g_r.start) + RAW_W'(bi[8:2]));
    job1 = '{wr: s1_wr_r, hit: hit, phase: bi[1:0], w: s1_g_r.w, ox: s1_g_r.ox,
             data: s1_byte_r};
  end

  assign prod = PW'(s2_raw_r) * PW'(RECIP);

  // wrap: remainder from the estimate, then one correction
  assign rem0 = CMP_W'(s3_raw_r) - CMP_W'(s3_q_r) * BMAX;
  assign rem1 = (rem0 >= BMAX) ? rem0 - BMAX : rem0;

  assign jq_push = s3_v_r && !jq_full;
  assign jq_job  = s3_job_r;
  assign jq_addr = AW'(rem1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= acc && (in_operation == OP_RENDER || (in_operation == OP_BYTE && baddr_ok));
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_wr_r    <= (in_operation == OP_BYTE);
      s1_gn_ok_r <= gn_ok;
      s1_row_r   <= in_text_row;
      s1_addr_r  <= in_table_address;
      s1_byte_r  <= in_bitmap_byte;
      s2_job_r   <= job1;
      s2_raw_r   <= raw1;
      s3_job_r   <= s2_job_r;
      s3_raw_r   <= s2_raw_r;
      s3_q_r     <= QW'(prod >> RSH);
    end
  end

endmodule

### sv/grr_back.sv
// Back end: bitmap store, row fetch and pixel word emission.
module grr_back #(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [15:0]                     cfg_wr_data,
  input  logic                            jq_empty,
  input  grr_pkg::grr_job_t               jq_job,
  input  logic [$clog2(BITMAP_BYTES)-1:0] jq_addr,
  output logic                            jq_pop,
  input  logic                            oq_full,
  output logic                            oq_push,
  output logic [31:0]                     oq_word,
  output logic                            oq_last
);
  import grr_pkg::*;

  localparam int AW  = $clog2(BITMAP_BYTES);
  localparam int AW1 = AW + 1;
  localparam logic [AW:0] BMAX = AW1'(BITMAP_BYTES);

  logic [7:0]  bmp_mem [BITMAP_BYTES];
  logic [7:0]  rd_r, b0_r, b1_r, b0_nxt, b1_nxt;
  logic [15:0] bg_r;
  grr_fetch_t  fs_r, fs_nxt;

  logic          rd_en, wr_en, hand;
  logic [AW-1:0] rd_addr, a1, a2;
  logic [AW:0]   p1, p2;
  logic [15:0]   hand_row, row_calc, win, mask;
  logic [23:0]   bits24;
  logic [3:0]    wm;

  logic          em_busy_r;
  logic [2:0]    em_cnt_r;
  logic [15:0]   em_row_r;
  logic          em_last, em_free;
  logic [3:0]    nib;

  assign p1 = {1'b0, jq_addr} + AW1'(1);
  assign p2 = {1'b0, jq_addr} + AW1'(2);
  assign a1 = (p1 >= BMAX) ? AW'(p1 - BMAX) : AW'(p1);
  assign a2 = (p2 >= BMAX) ? AW'(p2 - BMAX) : AW'(p2);

  // align the 16-bit pixel window, clear past the width, shift by x offset
  always_comb begin
    bits24   = {b0_r, b1_r, rd_r};
    win      = 16'(bits24 >> (5'd8 - {2'b0, jq_job.phase, 1'b0}));
    wm       = (jq_job.w > 4'd8) ? 4'd8 : jq_job.w;
    mask     = 16'hffff << {4'd8 - wm, 1'b0};
    row_calc = (win & mask) >> {jq_job.ox, 1'b0};
  end

  assign em_last = (em_cnt_r == 3'(WORDS - 1));
  assign em_free = !em_busy_r || (em_last && !oq_full);

  always_comb begin
    fs_nxt   = fs_r;
    jq_pop   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = jq_addr;
    wr_en    = 1'b0;
    hand     = 1'b0;
    hand_row = 16'h0000;
    b0_nxt   = b0_r;
    b1_nxt   = b1_r;
    case (fs_r)
      F_B0: begin
        if (!jq_empty) begin
          if (jq_job.wr) begin
            wr_en  = 1'b1;
            jq_pop = 1'b1;
          end else if (!jq_job.hit) begin
            if (em_free) begin
              hand   = 1'b1;
              jq_pop = 1'b1;
            end
          end else begin
            rd_en  = 1'b1;
            fs_nxt = F_B1;
          end
        end
      end
      F_B1: begin
        rd_en   = 1'b1;
        rd_addr = a1;
        b0_nxt  = rd_r;
        fs_nxt  = F_B2;
      end
      F_B2: begin
        rd_en   = 1'b1;
        rd_addr = a2;
        b1_nxt  = rd_r;
        fs_nxt  = F_HAND;
      end
      F_HAND: begin
        if (em_free) begin
          hand     = 1'b1;
          hand_row = row_calc;
          jq_pop   = 1'b1;
          fs_nxt   = F_B0;
        end
      end
      default: fs_nxt = F_B0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) bmp_mem[jq_addr] <= jq_job.data;
    if (rd_en) rd_r <= bmp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r      <= F_B0;
      bg_r      <= BG_RESET;
      em_busy_r <= 1'b0;
      em_cnt_r  <= 3'd0;
    end else begin
      fs_r <= fs_nxt;
      if (cfg_wr_en) bg_r <= cfg_wr_data;
      if (hand) begin
        em_busy_r <= 1'b1;
        em_cnt_r  <= 3'd0;
      end else if (em_busy_r && !oq_full) begin
        if (em_last) em_busy_r <= 1'b0;
        em_cnt_r <= em_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    if (hand) em_row_r <= hand_row;
    else if (em_busy_r && !oq_full) em_row_r <= em_row_r << 4;
  end

  // leftmost pixel of the nibble goes to the low half
  assign nib     = em_row_r[15:12];
  assign oq_push = em_busy_r;
  assign oq_word = {bg_r + level_offset(nib[1:0]), bg_r + level_offset(nib[3:2])};
  assign oq_last = em_last;

endmodule

### sv/glyph_row_renderer_2bpp.sv
// Top level of the 2-bit anti-aliased glyph row renderer.
//
// Character generator for one scanline of text. Items enter through a queue-style
// port (push/full) and results leave through another (empty/pop). A descriptor
// write (width, height, x/y offset, bitmap start) fills the glyph table and a
// byte write fills the bitmap store; neither store is cleared at reset, so read
// only what was written. A render item names a character and a scanline and
// produces five 32-bit words of two 16-bit pixels each, first pixel in the low
// half, with last_word set on the fifth. Each pixel is the background colour
// plus its 2-bit level times 0x4208, wrapping in 16 bits; rows outside the
// glyph box, glyphs of zero width and codes without a glyph give background.
// The background colour is written on cfg_wr_en and resets to 0x20c3; change it
// only while the block is idle.
// The word emitter sends one word a cycle while the output queue has room; the
// three bitmap byte reads of the next row (single-port store, one read a cycle)
// and its handoff overlap the current emission. Writes pass at one per cycle
// unless a row fetch ahead of them holds the job queue. A render item passes
// three front stages (glyph lookup, row locate, address wrap), the job queue,
// the byte fetch and handoff states, then the emitter and the output queue.
module glyph_row_renderer_2bpp #(
  parameter int TEXT_LINE_HEIGHT = 10,
  parameter int GLYPH_COUNT      = 96,
  parameter int BITMAP_BYTES     = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: background colour
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  // input items
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_operation,
  input  logic [6:0]        in_char_code,
  input  logic [4:0]        in_text_row,
  input  logic [11:0]       in_table_address,
  input  logic [7:0]        in_bitmap_byte,
  input  logic [3:0]        in_glyph_width,
  input  logic [4:0]        in_glyph_height,
  input  logic [2:0]        in_glyph_offset_x,
  input  logic signed [5:0] in_glyph_offset_y,
  input  logic [11:0]       in_glyph_bitmap_start,
  // result words
  output logic              out_empty,
  input  logic              out_pop,
  output logic [31:0]       out_pixel_pair,
  output logic              out_last_word
);
  import grr_pkg::*;

  localparam int AW = $clog2(BITMAP_BYTES);
  localparam int JW = $bits(grr_job_t) + AW;

  // front-to-back job queue
  logic          jq_push, jq_full, jq_pop, jq_empty;
  grr_job_t      jq_job_in, jq_job_out;
  logic [AW-1:0] jq_addr_in, jq_addr_out;
  logic [JW-1:0] jq_din, jq_dout;

  // back-to-port result queue: {last_word, pixel_pair}
  logic          oq_push, oq_full, oq_last;
  logic [31:0]   oq_word;
  logic [32:0]   oq_dout;

  // Front: take every transfer, update the glyph table on descriptor writes,
  // and turn render items into a bitmap byte address plus alignment info.
  grr_front #(
    .TEXT_LINE_HEIGHT (TEXT_LINE_HEIGHT),
    .GLYPH_COUNT      (GLYPH_COUNT),
    .BITMAP_BYTES     (BITMAP_BYTES)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_operation          (in_operation),
    .in_char_code          (in_char_code),
    .in_text_row           (in_text_row),
    .in_table_address      (in_table_address),
    .in_bitmap_byte        (in_bitmap_byte),
    .in_glyph_width        (in_glyph_width),
    .in_glyph_height       (in_glyph_height),
    .in_glyph_offset_x     (in_glyph_offset_x),
    .in_glyph_offset_y     (in_glyph_offset_y),
    .in_glyph_bitmap_start (in_glyph_bitmap_start),
    .jq_push               (jq_push),
    .jq_full               (jq_full),
    .jq_job                (jq_job_in),
    .jq_addr               (jq_addr_in)
  );

  // Jobs stay in order, so a byte write never overtakes an earlier row fetch.
  assign jq_din = {jq_job_in, jq_addr_in};
  assign {jq_job_out, jq_addr_out} = jq_dout;

  grr_queue #(
    .W (JW)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .full  (jq_full),
    .din   (jq_din),
    .pop   (jq_pop),
    .empty (jq_empty),
    .dout  (jq_dout)
  );

  // Back: apply byte writes, fetch three bytes per visible row, emit five words.
  grr_back #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .jq_empty    (jq_empty),
    .jq_job      (jq_job_out),
    .jq_addr     (jq_addr_out),
    .jq_pop      (jq_pop),
    .oq_full     (oq_full),
    .oq_push     (oq_push),
    .oq_word     (oq_word),
    .oq_last     (oq_last)
  );

  // Output queue: hold finished words so the emitter keeps going while the
  // consumer stalls, until both entries are full.
  grr_queue #(
    .W (33)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .full  (oq_full),
    .din   ({oq_last, oq_word}),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (oq_dout)
  );

  assign out_pixel_pair = oq_dout[31:0];
  assign out_last_word  = oq_dout[32];

endmodule

### tb/glyph_row_renderer_2bpp_tb.sv
// Self-checking testbench for the 2bpp glyph row renderer.
module glyph_row_renderer_2bpp_tb;
  import grr_pkg::*;

  localparam int TEXT_LINE_HEIGHT = 10;
  localparam int GLYPH_COUNT      = 96;
  localparam int BITMAP_BYTES     = 4096;
  localparam int DRAIN_CYCLES     = 24;     // well past the render latency
  localparam int PHASE_ITEMS      = 55;
  localparam logic [1:0] OP_NOP   = 2'd3;   // unused code, the block drops it

  typedef struct {
    logic [1:0]        op;
    logic [6:0]        code;
    logic [4:0]        row;
    logic [11:0]       addr;
    logic [7:0]        data;
    logic [3:0]        w;
    logic [4:0]        h;
    logic [2:0]        ox;
    logic signed [5:0] oy;
    logic [11:0]       start;
  } glyph_item_t;

  typedef struct packed {
    logic [31:0] pair;
    logic        last;
  } pixel_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [15:0]       cfg_wr_data = '0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [1:0]        in_operation = '0;
  logic [6:0]        in_char_code = '0;
  logic [4:0]        in_text_row = '0;
  logic [11:0]       in_table_address = '0;
  logic [7:0]        in_bitmap_byte = '0;
  logic [3:0]        in_glyph_width = '0;
  logic [4:0]        in_glyph_height = '0;
  logic [2:0]        in_glyph_offset_x = '0;
  logic signed [5:0] in_glyph_offset_y = '0;
  logic [11:0]       in_glyph_bitmap_start = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [31:0]       out_pixel_pair;
  logic              out_last_word;

  glyph_row_renderer_2bpp #(
    .TEXT_LINE_HEIGHT(TEXT_LINE_HEIGHT),
    .GLYPH_COUNT(GLYPH_COUNT),
    .BITMAP_BYTES(BITMAP_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_push(in_push),
    .in_full(in_full),
    .in_operation(in_operation),
    .in_char_code(in_char_code),
    .in_text_row(in_text_row),
    .in_table_address(in_table_address),
    .in_bitmap_byte(in_bitmap_byte),
    .in_glyph_width(in_glyph_width),
    .in_glyph_height(in_glyph_height),
    .in_glyph_offset_x(in_glyph_offset_x),
    .in_glyph_offset_y(in_glyph_offset_y),
    .in_glyph_bitmap_start(in_glyph_bitmap_start),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pixel_pair(out_pixel_pair),
    .out_last_word(out_last_word)
  );

  // Predictor state: updated only when an item is actually transferred in.
  logic [15:0] base_color = BG_RESET;
  grr_glyph_t  glyph_tbl [GLYPH_COUNT];
  logic [7:0]  bitmap_mem [BITMAP_BYTES];
  pixel_word_t pixel_words_due [$];

  // Stimulus-side view of the stores: tracks what has been queued so far, so
  // that no render ever reads a descriptor or bitmap byte that was never written.
  grr_glyph_t  plan_glyph [GLYPH_COUNT];
  bit          plan_glyph_set [GLYPH_COUNT];
  bit          plan_byte_set [BITMAP_BYTES];
  glyph_item_t pending_items [$];
  glyph_item_t in_flight;
  int          stim_count = 0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Row of the glyph box that a text row falls on; bi is the first pixel index.
  function automatic bit row_in_box(input grr_glyph_t g, input logic [4:0] row,
                                    output int bi);
    int ey;
    ey = int'(row) - TEXT_LINE_HEIGHT + 4 + int'($signed(g.oy)) + int'(g.h);
    bi = int'(g.w) * ey;
    return (ey >= 0) && (ey < int'(g.h)) && (g.w != 4'd0);
  endfunction

  function automatic logic [15:0] shade(input logic [15:0] bg, input logic [1:0] lvl);
    return 16'(bg + lvl * LEVEL_STEP);
  endfunction

  // Advance the predictor by one transferred item; renders queue five words.
  task automatic apply_item(input glyph_item_t it);
    logic [31:0] row_words [WORDS];
    grr_glyph_t  g;
    logic [23:0] raw;
    logic [15:0] bits;
    int          gn, bi, base, wm, k;
    case (it.op)
      OP_DESC: begin
        if (it.addr < GLYPH_COUNT) glyph_tbl[it.addr] = {it.w, it.h, it.ox, it.oy, it.start};
      end
      OP_BYTE: bitmap_mem[it.addr] = it.data;
      OP_RENDER: begin
        for (k = 0; k < WORDS; k++) row_words[k] = {base_color, base_color};
        gn = int'(it.code) - int'(FIRST_CODE);
        if (gn >= 0 && gn < GLYPH_COUNT) begin
          g = glyph_tbl[gn];
          if (row_in_box(g, it.row, bi)) begin
            base = int'(g.start) + bi / 4;
            raw = {bitmap_mem[base % BITMAP_BYTES], bitmap_mem[(base + 1) % BITMAP_BYTES],
                   bitmap_mem[(base + 2) % BITMAP_BYTES]};
            // Line up the first pixel at bits 15..14, clear past the width,
            // then slide right by the x offset.
            bits = 16'(raw >> (8 - 2 * (bi % 4)));
            wm = (g.w > 4'd8) ? 8 : int'(g.w);
            bits &= 16'(16'hffff << (2 * (8 - wm)));
            bits >>= 2 * g.ox;
            for (k = 0; k < 4; k++) begin
              row_words[k] = {shade(base_color, bits[13-4*k -: 2]),
                              shade(base_color, bits[15-4*k -: 2])};
            end
          end
        end
        for (k = 0; k < WORDS; k++) pixel_words_due.push_back({row_words[k], k == WORDS - 1});
      end
      default: ;
    endcase
  endtask

  function automatic glyph_item_t noise_item();
    glyph_item_t it;
    it.op    = 2'($urandom);
    it.code  = 7'($urandom);
    it.row   = 5'($urandom);
    it.addr  = 12'($urandom);
    it.data  = 8'($urandom);
    it.w     = 4'($urandom);
    it.h     = 5'($urandom);
    it.ox    = 3'($urandom);
    it.oy    = 6'($urandom);
    it.start = 12'($urandom);
    return it;
  endfunction

  task automatic queue_item(input glyph_item_t it);
    pending_items.push_back(it);
    if (it.op == OP_DESC && it.addr < GLYPH_COUNT) begin
      plan_glyph[it.addr] = {it.w, it.h, it.ox, it.oy, it.start};
      plan_glyph_set[it.addr] = 1'b1;
    end
    if (it.op == OP_BYTE) plan_byte_set[it.addr] = 1'b1;
    if (it.op == OP_RENDER || it.op == OP_BYTE || (it.op == OP_DESC && it.addr < GLYPH_COUNT))
      stim_count++;
  endtask

  task automatic queue_desc(input int gn, input logic [3:0] w, input logic [4:0] h,
                            input logic [2:0] ox, input logic signed [5:0] oy,
                            input logic [11:0] start);
    glyph_item_t it;
    it = noise_item();
    it.op = OP_DESC;
    it.addr = 12'(gn);
    it.w = w;
    it.h = h;
    it.ox = ox;
    it.oy = oy;
    it.start = start;
    queue_item(it);
  endtask

  task automatic queue_byte(input int addr, input logic [7:0] data);
    glyph_item_t it;
    it = noise_item();
    it.op = OP_BYTE;
    it.addr = 12'(addr);
    it.data = data;
    queue_item(it);
  endtask

  // Mostly narrow glyphs, some empty and some wider than the eight columns;
  // half the bitmaps sit in the low 256 bytes so bytes get reused.
  task automatic queue_random_desc(input int gn);
    logic [3:0] w;
    int         r;
    r = $urandom_range(99);
    if (r < 80) w = 4'($urandom_range(8, 1));
    else if (r < 90) w = 4'd0;
    else w = 4'($urandom_range(15, 9));
    queue_desc(gn, w, 5'($urandom), 3'($urandom), 6'($urandom),
               12'($urandom_range(99) < 50 ? $urandom_range(255) : $urandom_range(4095)));
  endtask

  // Queue a render; first load the descriptor and any bitmap byte it reads
  // that has not been written yet.
  task automatic queue_render(input logic [6:0] code, input logic [4:0] row);
    glyph_item_t it;
    int          gn, bi, base, i;
    gn = int'(code) - int'(FIRST_CODE);
    if (gn >= 0 && gn < GLYPH_COUNT) begin
      if (!plan_glyph_set[gn]) queue_random_desc(gn);
      if (row_in_box(plan_glyph[gn], row, bi)) begin
        base = int'(plan_glyph[gn].start) + bi / 4;
        for (i = 0; i < 3; i++) begin
          if (!plan_byte_set[(base + i) % BITMAP_BYTES])
            queue_byte((base + i) % BITMAP_BYTES, 8'($urandom));
        end
      end
    end
    it = noise_item();
    it.op = OP_RENDER;
    it.code = code;
    it.row = row;
    queue_item(it);
  endtask

  function automatic int pick_loaded_glyph();
    int gn;
    do gn = $urandom_range(GLYPH_COUNT - 1); while (!plan_glyph_set[gn]);
    return gn;
  endfunction

  // Text row that lands inside the glyph box, where one exists.
  function automatic logic [4:0] aimed_row(input int gn);
    int row;
    if (plan_glyph[gn].h == 5'd0) return 5'($urandom);
    row = $urandom_range(int'(plan_glyph[gn].h) - 1) + TEXT_LINE_HEIGHT - 4
          - int'($signed(plan_glyph[gn].oy)) - int'(plan_glyph[gn].h);
    return (row >= 0 && row <= 31) ? 5'(row) : 5'($urandom);
  endfunction

  task automatic directed_items();
    glyph_item_t it;
    // Glyph 0 (code 31): one row, bits in the first three bytes.
    queue_desc(0, 4'd8, 5'd1, 3'd0, 6'sd5, 12'd0);
    queue_byte(0, 8'hff);
    queue_byte(1, 8'h00);
    queue_byte(2, 8'h1b);
    queue_render(7'd31, 5'd0);
    // Last glyph: tallest box, lowest y offset, bitmap at the top of the store
    // so the row fetch wraps around to byte 0.
    queue_desc(GLYPH_COUNT - 1, 4'd8, 5'd31, 3'd0, 6'(-32), 12'd4095);
    queue_byte(4095, 8'hff);
    queue_render(7'd126, 5'd7);
    queue_render(7'd126, 5'd31);
    queue_render(7'd126, 5'd0);     // above the box
    // Zero width inside the box height still gives background.
    queue_desc(1, 4'd0, 5'd10, 3'd3, 6'sd0, 12'd100);
    queue_render(7'd32, 5'd5);
    // Width above eight with the largest x offset.
    queue_desc(2, 4'd15, 5'd4, 3'd7, 6'sd2, 12'd2000);
    queue_render(7'd33, 5'd3);
    queue_render(7'd33, 5'd0);
    // Zero height never matches.
    queue_desc(3, 4'd5, 5'd0, 3'd2, 6'sd31, 12'd300);
    queue_render(7'd34, 5'd6);
    // Codes without a glyph.
    queue_render(7'd0, 5'd31);
    queue_render(7'd30, 5'd4);
    queue_render(7'd127, 5'd8);
    // Descriptor writes past the table are dropped, as is the unused op code.
    queue_desc(GLYPH_COUNT, 4'd8, 5'd31, 3'd0, 6'sd0, 12'd0);
    queue_desc(4095, 4'd8, 5'd31, 3'd0, 6'sd0, 12'd0);
    it = noise_item();
    it.op = OP_NOP;
    queue_item(it);
    queue_render(7'd31, 5'd0);
  endtask

  task automatic random_items(input int count);
    glyph_item_t it;
    int          r, gn, target;
    target = stim_count + count;
    while (stim_count < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_render(r < 4 ? 7'($urandom_range(30)) : 7'd127, 5'($urandom));
      end else if (r < 58) begin
        gn = pick_loaded_glyph();
        queue_render(7'(gn + 31), aimed_row(gn));
      end else if (r < 66) begin
        gn = pick_loaded_glyph();
        queue_render(7'(gn + 31), 5'($urandom));
      end else if (r < 78) begin
        queue_random_desc($urandom_range(GLYPH_COUNT - 1));
      end else if (r < 92) begin
        queue_byte(r % 2 ? $urandom_range(255) : $urandom_range(4095), 8'($urandom));
      end else if (r < 96) begin
        it = noise_item();
        it.op = OP_DESC;
        it.addr = 12'($urandom_range(4095, GLYPH_COUNT));
        queue_item(it);
      end else begin
        it = noise_item();
        it.op = OP_NOP;
        queue_item(it);
      end
    end
  endtask

  // Wait until every item is in and every word is out, then let writes settle.
  // Sample between edges so the driver's updates of this edge are visible.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_push || pixel_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle; the background register takes the value
  // on the edge that sees cfg_wr_en high.
  task automatic set_background(input logic [15:0] color);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_color = color;
  endtask

  // Driver: present the next pending item; hold it while full is high.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) apply_item(in_flight);
      if (!in_push || !in_full) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_flight = pending_items.pop_front();
          in_push <= 1'b1;
          in_operation <= in_flight.op;
          in_char_code <= in_flight.code;
          in_text_row <= in_flight.row;
          in_table_address <= in_flight.addr;
          in_bitmap_byte <= in_flight.data;
          in_glyph_width <= in_flight.w;
          in_glyph_height <= in_flight.h;
          in_glyph_offset_x <= in_flight.ox;
          in_glyph_offset_y <= in_flight.oy;
          in_glyph_bitmap_start <= in_flight.start;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each word on its transfer against the oldest one due.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pixel_words_due.size() == 0) begin
          $error("unexpected word: pixel_pair %h last_word %b", out_pixel_pair, out_last_word);
          failures++;
        end else begin
          if (out_pixel_pair !== pixel_words_due[0].pair) begin
            $error("pixel_pair: expected %h, actual %h", pixel_words_due[0].pair,
                   out_pixel_pair);
            failures++;
          end
          if (out_last_word !== pixel_words_due[0].last) begin
            $error("last_word: expected %b, actual %b", pixel_words_due[0].last,
                   out_last_word);
            failures++;
          end
          void'(pixel_words_due.pop_front());
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset color, no idling.
    directed_items();
    drain();

    // Random phases: each with its own color and idling pattern. Full white
    // makes every grey level wrap.
    set_background(16'hffff);
    random_items(PHASE_ITEMS);
    drain();

    set_background(16'h0000);
    sender_idle_pct = 82;
    random_items(PHASE_ITEMS);
    drain();

    set_background(16'($urandom));
    sender_idle_pct = 0;
    recv_stall_pct = 82;
    random_items(PHASE_ITEMS);
    drain();

    set_background(16'($urandom));
    sender_idle_pct = 28;
    recv_stall_pct = 28;
    random_items(PHASE_ITEMS);
    drain();

    if (failures == 0 && pixel_words_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
